[rtl/utf8sd_pkg.sv]
// ============================================================================
// utf8sd_pkg
// Types and constants shared by the UTF-8 stream decoder modules.
// ============================================================================
package utf8sd_pkg;

    localparam int CP_W      = 21;
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = $clog2(Q_DEPTH);

    localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;

    localparam logic [2:0] SEQ_NONE = 3'd0;
    localparam logic [2:0] SEQ_LEN2 = 3'd2;
    localparam logic [2:0] SEQ_LEN3 = 3'd3;
    localparam logic [2:0] SEQ_LEN4 = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            replaced;
        logic            run_last;
        logic            stream_done;
    } t_out;

    // one accepted byte, as a list of results for the back end
    typedef struct packed {
        logic            fin;
        logic [1:0]      rep_count;
        logic            has_cp;
        logic            cp_rep;
        logic [CP_W-1:0] cp;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic avail;
    } t_q_status;

endpackage

[rtl/utf8sd_front.sv]
// ============================================================================
// utf8sd_front
// Accepts bytes, tracks the pending sequence and turns each byte into a
// command: a count of replacement results and an optional code point.
// ============================================================================
module utf8sd_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  utf8sd_pkg::t_in         i_data,
    input  utf8sd_pkg::t_q_status   i_q_status,
    output logic                    o_push,
    output utf8sd_pkg::t_cmd        o_cmd
);
    import utf8sd_pkg::*;

    logic [2:0]      r_len, n_len;
    logic [1:0]      r_cs, n_cs;
    logic [CP_W-1:0] r_pv, n_pv;

    logic            accept;
    logic            fresh;
    logic [1:0]      cs1;
    logic [CP_W-1:0] pv_ext;
    t_cmd            cmd;

    assign o_ready = !i_q_status.full;
    assign accept  = i_valid && o_ready;
    assign cs1     = r_cs + 2'd1;
    assign pv_ext  = {r_pv[CP_W-7:0], i_data.data_byte[5:0]};

    always_comb begin
        n_len = r_len;
        n_cs  = r_cs;
        n_pv  = r_pv;
        cmd   = '0;
        cmd.fin = i_data.final_byte;
        fresh = 1'b0;

        if (r_len != SEQ_NONE) begin
            if (i_data.data_byte[7:6] == 2'b10) begin
                if (({1'b0, cs1} + 3'd1) >= r_len) begin
                    cmd.has_cp = 1'b1;
                    cmd.cp     = pv_ext;
                    n_len      = SEQ_NONE;
                    n_cs       = 2'd0;
                    n_pv       = '0;
                end else if (i_data.final_byte) begin
                    cmd.rep_count = cs1 + 2'd1;
                    n_len         = SEQ_NONE;
                    n_cs          = 2'd0;
                    n_pv          = '0;
                end else begin
                    n_cs = cs1;
                    n_pv = pv_ext;
                end
            end else begin
                if (i_data.final_byte && (({1'b0, r_cs} + 3'd2) < r_len)) begin
                    cmd.rep_count = r_cs + 2'd1;
                end else begin
                    cmd.rep_count = 2'd1;
                end
                n_len = SEQ_NONE;
                n_cs  = 2'd0;
                n_pv  = '0;
                fresh = 1'b1;
            end
        end else begin
            fresh = 1'b1;
        end

        if (fresh) begin
            case (i_data.data_byte) inside
                8'b0???_????: begin
                    cmd.has_cp = 1'b1;
                    cmd.cp     = {13'd0, i_data.data_byte};
                end
                8'b110?_????: begin
                    n_len = SEQ_LEN2;
                    n_pv  = {16'd0, i_data.data_byte[4:0]};
                end
                8'b1110_????: begin
                    n_len = SEQ_LEN3;
                    n_pv  = {17'd0, i_data.data_byte[3:0]};
                end
                8'b1111_0???: begin
                    n_len = SEQ_LEN4;
                    n_pv  = {18'd0, i_data.data_byte[2:0]};
                end
                default: begin
                    cmd.has_cp = 1'b1;
                    cmd.cp_rep = 1'b1;
                    cmd.cp     = REPL_CP;
                end
            endcase
            n_cs = 2'd0;
            if (n_len != SEQ_NONE && i_data.final_byte) begin
                cmd.has_cp = 1'b1;
                cmd.cp_rep = 1'b1;
                cmd.cp     = REPL_CP;
            end
        end

        if (i_data.final_byte) begin
            n_len = SEQ_NONE;
            n_cs  = 2'd0;
            n_pv  = '0;
        end
    end

    assign o_push = accept && (cmd.rep_count != 2'd0 || cmd.has_cp);
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= SEQ_NONE;
            r_cs  <= 2'd0;
            r_pv  <= '0;
        end else if (accept) begin
            r_len <= n_len;
            r_cs  <= n_cs;
            r_pv  <= n_pv;
        end
    end

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len == SEQ_NONE || r_len == SEQ_LEN2 || r_len == SEQ_LEN3 || r_len == SEQ_LEN4)
        else $error("pending length out of range");

    a_fin_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_data.final_byte |=> r_len == SEQ_NONE)
        else $error("state not cleared after final byte");

endmodule

[rtl/utf8sd_queue.sv]
// ============================================================================
// utf8sd_queue
// Short command queue between the front and back ends.
// ============================================================================
module utf8sd_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  utf8sd_pkg::t_cmd        i_cmd,
    input  logic                    i_pop,
    output utf8sd_pkg::t_cmd        o_head,
    output utf8sd_pkg::t_q_status   o_status
);
    import utf8sd_pkg::*;

    t_cmd          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr, r_rd;
    logic [Q_AW:0]   r_cnt;

    assign o_status.full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_status.avail = (r_cnt != '0);
    assign o_head         = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + Q_AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (Q_AW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (Q_AW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_status.full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_status.avail))
        else $error("pop from empty queue");

endmodule

[rtl/utf8sd_back.sv]
// ============================================================================
// utf8sd_back
// Expands queued commands into results, one per cycle while the output side
// takes them, into the output register.
// ============================================================================
module utf8sd_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  utf8sd_pkg::t_cmd        i_head,
    input  utf8sd_pkg::t_q_status   i_q_status,
    output logic                    o_pop,
    output logic                    o_valid,
    input  logic                    i_ready,
    output utf8sd_pkg::t_out        o_data
);
    import utf8sd_pkg::*;

    logic [1:0] r_idx;
    logic       r_valid;
    t_out       r_data;

    logic       load;
    logic       is_rep;
    logic       is_last;
    logic [2:0] total;

    assign total   = {1'b0, i_head.rep_count} + {2'b00, i_head.has_cp};
    assign is_rep  = r_idx < i_head.rep_count;
    assign is_last = ({1'b0, r_idx} + 3'd1) == total;
    assign load    = i_q_status.avail && (!r_valid || i_ready);
    assign o_pop   = load && is_last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data.code_point  <= is_rep ? REPL_CP : i_head.cp;
            r_data.replaced    <= is_rep ? 1'b1 : i_head.cp_rep;
            r_data.run_last    <= is_last;
            r_data.stream_done <= is_last && i_head.fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx <= is_last ? 2'd0 : r_idx + 2'd1;
            end
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

    a_idx_in_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_status.avail |-> ({1'b0, r_idx} < total))
        else $error("result index past end of command");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.stream_done |-> o_data.run_last)
        else $error("stream end not on last result of item");

endmodule

[rtl/utf8_stream_decoder_core.sv]
// ============================================================================
// utf8_stream_decoder_core
// UTF-8 byte stream to code point decoder with U+FFFD replacement.
// ============================================================================
// Takes one byte per cycle while the queue has room and gives one result
// per cycle while the output side is ready, so the output side alone sets
// the pace. Most bytes give zero or one result; an error can give up to
// three. A four-entry command queue sits between the byte classifier and
// the result expander; the input stalls only when it is full. A byte's
// results pass through the queue and then the output register.
module utf8_stream_decoder_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  utf8sd_pkg::t_in      i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output utf8sd_pkg::t_out     o_data
);
    import utf8sd_pkg::*;

    t_q_status q_status;
    t_cmd      push_cmd;
    t_cmd      head_cmd;
    logic      push;
    logic      pop;

    utf8sd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .i_q_status (q_status),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    utf8sd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_head   (head_cmd),
        .o_status (q_status)
    );

    utf8sd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head_cmd),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data)
    );

endmodule

[tb/utf8_decode_checker.sv]
`timescale 1ns / 100ps
// ============================================================================
// utf8_decode_checker
// Watches both item channels of the UTF-8 stream decoder, works out the code
// points each accepted byte should give and compares every result item, field
// by field, with the oldest one still owed. Mismatches are counted.
// ============================================================================
module utf8_decode_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  utf8sd_pkg::t_in      i_in_item,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  utf8sd_pkg::t_out     i_out_item,
    output int                   o_fail_count,
    output int                   o_pending
);
    import utf8sd_pkg::*;

    logic [2:0]      seq_len = SEQ_NONE;
    logic [1:0]      cont_cnt = '0;
    logic [CP_W-1:0] partial = '0;

    t_out            step_res [0:2];
    int              step_cnt;
    t_out            cp_expected [$];
    int              fail_count = 0;
    int              pending_cnt = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_cnt;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic add_result(input logic [CP_W-1:0] cp, input logic rep);
        step_res[step_cnt] = '{code_point: cp, replaced: rep, run_last: 1'b0,
                               stream_done: 1'b0};
        step_cnt++;
    endtask

    task automatic clear_seq();
        seq_len  = SEQ_NONE;
        cont_cnt = '0;
        partial  = '0;
    endtask

    task automatic decode_lead(input logic [7:0] b, input logic fin);
        logic [2:0]      len;
        logic [CP_W-1:0] lead_bits;
        len       = SEQ_NONE;
        lead_bits = '0;
        if (b[7] == 1'b0) begin
            add_result({13'd0, b}, 1'b0);
        end else if (b[7:5] == 3'b110) begin
            len       = SEQ_LEN2;
            lead_bits = {16'd0, b[4:0]};
        end else if (b[7:4] == 4'b1110) begin
            len       = SEQ_LEN3;
            lead_bits = {17'd0, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
            len       = SEQ_LEN4;
            lead_bits = {18'd0, b[2:0]};
        end else begin
            add_result(REPL_CP, 1'b1);
        end
        if (len != SEQ_NONE) begin
            if (fin) begin
                add_result(REPL_CP, 1'b1);
            end else begin
                seq_len  = len;
                cont_cnt = '0;
                partial  = lead_bits;
            end
        end
    endtask

    task automatic predict_byte(input t_in item);
        logic [7:0] b;
        logic       fin;
        int         n_repl;
        b        = item.data_byte;
        fin      = item.final_byte;
        step_cnt = 0;
        if (seq_len != SEQ_NONE) begin
            if (b[7:6] == 2'b10) begin
                partial  = {partial[CP_W-7:0], b[5:0]};
                cont_cnt = cont_cnt + 2'd1;
                if (int'(cont_cnt) + 1 >= int'(seq_len)) begin
                    add_result(partial, 1'b0);
                    clear_seq();
                end else if (fin) begin
                    repeat (int'(cont_cnt) + 1) add_result(REPL_CP, 1'b1);
                    clear_seq();
                end
            end else begin
                n_repl = (fin && int'(cont_cnt) + 2 < int'(seq_len)) ?
                         int'(cont_cnt) + 1 : 1;
                repeat (n_repl) add_result(REPL_CP, 1'b1);
                clear_seq();
                decode_lead(b, fin);
            end
        end else begin
            decode_lead(b, fin);
        end
        if (fin) clear_seq();
        if (step_cnt > 0) begin
            step_res[step_cnt-1].run_last    = 1'b1;
            step_res[step_cnt-1].stream_done = fin;
        end
        for (int k = 0; k < step_cnt; k++) cp_expected.push_back(step_res[k]);
    endtask

    always @(posedge i_clk) begin : monitor
        t_out want;
        if (!i_rst_n) begin
            clear_seq();
            cp_expected.delete();
        end else begin
            if (i_in_valid && i_in_ready) predict_byte(i_in_item);
            if (i_out_valid && i_out_ready) begin
                if (cp_expected.size() == 0) begin
                    report_mismatch("unexpected item code_point",
                                    int'(i_out_item.code_point), 0);
                end else begin
                    want = cp_expected.pop_front();
                    if (i_out_item.code_point !== want.code_point)
                        report_mismatch("code_point", int'(i_out_item.code_point),
                                        int'(want.code_point));
                    if (i_out_item.replaced !== want.replaced)
                        report_mismatch("replaced", int'(i_out_item.replaced),
                                        int'(want.replaced));
                    if (i_out_item.run_last !== want.run_last)
                        report_mismatch("run_last", int'(i_out_item.run_last),
                                        int'(want.run_last));
                    if (i_out_item.stream_done !== want.stream_done)
                        report_mismatch("stream_done", int'(i_out_item.stream_done),
                                        int'(want.stream_done));
                end
            end
        end
        pending_cnt = cp_expected.size();
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb
// Stimulus and verdict for the UTF-8 stream decoder core.
// Feeds directed byte sequences and then random, mostly well-formed UTF-8
// with broken, truncated and stray bytes mixed in, under bursty input and a
// stalling output side; a checker beside the core predicts and compares.
// ============================================================================
module tb;
    import utf8sd_pkg::*;

    localparam int NUM_DIRECTED   = 26;
    localparam int RANDOM_ITEMS   = 255;
    localparam int HOLD_AT_ITEM   = 120;
    localparam int HOLD_CYCLES    = 60;
    localparam int DRAIN_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE} t_rx_mode;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic byte_valid = 1'b0;
    logic byte_ready;
    t_in  byte_item = '0;
    logic cp_valid;
    logic cp_ready = 1'b0;
    t_out cp_item;

    int   fail_count;
    int   pending;
    int   burst_left = 0;
    int   idle_cycles = 0;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;

    t_in  directed_items [0:NUM_DIRECTED-1] = '{
        {8'h00, 1'b0}, {8'h7F, 1'b0},
        {8'hC3, 1'b0}, {8'hA9, 1'b0},
        {8'hE2, 1'b0}, {8'h82, 1'b0}, {8'hAC, 1'b0},
        {8'hF7, 1'b0}, {8'hBF, 1'b0}, {8'hBF, 1'b0}, {8'hBF, 1'b0},
        {8'h80, 1'b0}, {8'hF8, 1'b0}, {8'hFF, 1'b0},
        {8'hE2, 1'b0}, {8'h41, 1'b0},
        {8'hF0, 1'b0}, {8'h90, 1'b0}, {8'h41, 1'b1},
        {8'hE2, 1'b0}, {8'h82, 1'b0}, {8'h41, 1'b1},
        {8'hC3, 1'b1},
        {8'hF0, 1'b0}, {8'h90, 1'b1},
        {8'hFF, 1'b1}
    };

    utf8_stream_decoder_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (byte_valid),
        .o_ready (byte_ready),
        .i_data  (byte_item),
        .o_valid (cp_valid),
        .i_ready (cp_ready),
        .o_data  (cp_item)
    );

    utf8_decode_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (byte_valid),
        .i_in_ready   (byte_ready),
        .i_in_item    (byte_item),
        .i_out_valid  (cp_valid),
        .i_out_ready  (cp_ready),
        .i_out_item   (cp_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        if ((byte_valid && byte_ready) || (cp_valid && cp_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 5);
            if (gap > 0) begin
                byte_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        byte_valid <= 1'b1;
        byte_item  <= {b, fin};
        @(posedge clk);
        while (!byte_ready) @(posedge clk);
        burst_left--;
        @(negedge clk);
    endtask

    initial begin : receiver
        t_rx_mode mode;
        int       run_left;
        mode     = RX_OPEN;
        run_left = 0;
        forever begin
            @(negedge clk);
            if (hold_req && !hold_done) begin
                cp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end else begin
                if (run_left == 0) begin
                    mode     = t_rx_mode'($urandom_range(0, 2));
                    run_left = $urandom_range(4, 40);
                end
                run_left--;
                case (mode)
                    RX_OPEN:  cp_ready <= 1'b1;
                    RX_COIN:  cp_ready <= ($urandom_range(0, 1) == 1);
                    default:  cp_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        logic [7:0] seq_bytes [0:3];
        int         seq_n;
        int         len;
        int         kind;
        int         sent;
        sent = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int k = 0; k < NUM_DIRECTED; k++)
            send_byte(directed_items[k].data_byte, directed_items[k].final_byte);

        while (sent < RANDOM_ITEMS) begin
            kind  = $urandom_range(0, 99);
            seq_n = 1;
            if (kind < 30) begin
                seq_bytes[0] = 8'($urandom_range(0, 127));
            end else if (kind < 90) begin
                if (kind < 50) len = 2;
                else if (kind < 65) len = 3;
                else if (kind < 80) len = 4;
                else len = $urandom_range(2, 4);
                case (len)
                    2:       seq_bytes[0] = 8'hC0 + 8'($urandom_range(0, 31));
                    3:       seq_bytes[0] = 8'hE0 + 8'($urandom_range(0, 15));
                    default: seq_bytes[0] = 8'hF0 + 8'($urandom_range(0, 7));
                endcase
                seq_n = (kind < 80) ? len : $urandom_range(1, len - 1);
                for (int k = 1; k < seq_n; k++)
                    seq_bytes[k] = 8'h80 + 8'($urandom_range(0, 63));
            end else begin
                seq_bytes[0] = 8'($urandom_range(0, 255));
            end
            for (int k = 0; k < seq_n; k++) begin
                send_byte(seq_bytes[k], $urandom_range(0, 29) == 0);
                sent++;
                if (sent == HOLD_AT_ITEM) hold_req = 1'b1;
            end
        end

        byte_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

[files.f]
rtl/utf8sd_pkg.sv
rtl/utf8sd_front.sv
rtl/utf8sd_queue.sv
rtl/utf8sd_back.sv
rtl/utf8_stream_decoder_core.sv
tb/utf8_decode_checker.sv
tb/tb.sv
